@@ rtl/core/pulse_count_sensor_scanner_macros.svh @@
// Assertion macros used by the scanner top level.
`ifndef PULSE_COUNT_SENSOR_SCANNER_MACROS_SVH
`define PULSE_COUNT_SENSOR_SCANNER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PCSS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PCSS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/pcss_pkg.sv @@
// Shared types and constants of the pulse-count sensor scanner.
package pcss_pkg;

    // Default geometry
    localparam int SLOTS_DEF      = 8;
    localparam int BANKS_DEF      = 3;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed field widths
    localparam int OUT_BITS     = 16;
    localparam int ELAPSED_BITS = 16;
    localparam int TIME_BITS    = 16;
    localparam int SLOT_FBITS   = 3;
    localparam int PHASE_BITS   = 2;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;
    localparam logic [TIME_BITS-1:0]    TIME_RESET  = TIME_BITS'(50);

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONV_TIME    = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_READOUT_TIME = CFG_IDX_BITS'(1);

    // Phase codes as reported on the result
    localparam logic [PHASE_BITS-1:0] PHASE_IDLE = PHASE_BITS'(0);
    localparam logic [PHASE_BITS-1:0] PHASE_CONV = PHASE_BITS'(1);
    localparam logic [PHASE_BITS-1:0] PHASE_READ = PHASE_BITS'(2);

    // Sequencer state
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_READ = 3'b100
    } t_state;

    // Per-item commands from the sequencer to every bank lane
    typedef struct packed {
        logic accept;
        logic count_en;
        logic count_clr;
        logic wr_en;
        logic rd_ok;
        logic rd_byp;
    } t_lane_ctl;

endpackage

@@ rtl/core/pulse_count_sensor_scanner.sv @@
// Top level of the pulse-count sensor scanner: sequencer, bank lanes, result merge.
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+------------------------------------------
//  input   | i_in_valid   | o_in_ready   | i_ms_tick, i_pulse_a/b/c, i_read_slot
//  result  | o_out_valid  | i_out_ready  | o_phase .. o_stored_c
//  config  | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  One item per cycle unless stalled; a transfer's result is registered for the next cycle.
//  The sequencer and all bank lanes update in the same cycle; the store read is registered.
//  A stalled result holds the input side only while the output register is full.
//  Synchronous active-low reset clears the sequencer, counters and store valid bits.
//  Config transfers are always taken (o_cfg_ready is high).
module pulse_count_sensor_scanner #(
    parameter int SLOTS      = pcss_pkg::SLOTS_DEF,
    parameter int BANKS      = pcss_pkg::BANKS_DEF,
    parameter int COUNT_BITS = pcss_pkg::COUNT_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_ms_tick,
    input  logic                                 i_pulse_a,
    input  logic                                 i_pulse_b,
    input  logic                                 i_pulse_c,
    input  logic [pcss_pkg::SLOT_FBITS-1:0]      i_read_slot,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [pcss_pkg::PHASE_BITS-1:0]      o_phase,
    output logic                                 o_power_on,
    output logic [pcss_pkg::SLOT_FBITS-1:0]      o_power_slot,
    output logic                                 o_reading_done,
    output logic [pcss_pkg::SLOT_FBITS-1:0]      o_done_slot,
    output logic [pcss_pkg::OUT_BITS-1:0]        o_done_count_a,
    output logic [pcss_pkg::OUT_BITS-1:0]        o_done_count_b,
    output logic [pcss_pkg::OUT_BITS-1:0]        o_done_count_c,
    output logic [pcss_pkg::OUT_BITS-1:0]        o_stored_a,
    output logic [pcss_pkg::OUT_BITS-1:0]        o_stored_b,
    output logic [pcss_pkg::OUT_BITS-1:0]        o_stored_c,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pcss_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [pcss_pkg::TIME_BITS-1:0]       i_cfg_data
);

    `include "pulse_count_sensor_scanner_macros.svh"

    localparam int SW = $clog2(SLOTS);

    logic                              r_out_vld;
    logic                              w_accept;
    pcss_pkg::t_lane_ctl               w_ctl;
    logic [SW-1:0]                     w_wr_addr;
    logic [SW-1:0]                     w_rd_addr;
    logic [SW-1:0]                     w_ptr;
    logic                              w_done;
    logic [BANKS-1:0]                  w_pulse;
    logic [pcss_pkg::OUT_BITS-1:0]     w_done_cnt [BANKS];
    logic [pcss_pkg::OUT_BITS-1:0]     w_stored   [BANKS];
    logic                              w_ph_idle;
    logic                              w_ph_conv;
    logic                              w_ph_read;
    logic                              w_idle_take;
    logic                              w_cnt_zero;

    // Take a new item whenever the output register is free or draining
    assign o_in_ready  = !r_out_vld || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_out_vld <= i_in_valid;
        end
    end

    pcss_ctrl #(
        .SLOTS (SLOTS),
        .SW    (SW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_ms_tick   (i_ms_tick),
        .i_read_slot (i_read_slot),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_lane_ctl  (w_ctl),
        .o_wr_addr   (w_wr_addr),
        .o_rd_addr   (w_rd_addr),
        .o_phase     (o_phase),
        .o_ptr       (w_ptr),
        .o_done      (w_done)
    );

    // One lane per bank; banks past the third have no pulse line
    for (genvar b = 0; b < BANKS; b++) begin : g_lane
        if (b == 0) begin : g_pa
            assign w_pulse[b] = i_pulse_a;
        end else if (b == 1) begin : g_pb
            assign w_pulse[b] = i_pulse_b;
        end else if (b == 2) begin : g_pc
            assign w_pulse[b] = i_pulse_c;
        end else begin : g_pn
            assign w_pulse[b] = 1'b0;
        end

        pcss_lane #(
            .SLOTS      (SLOTS),
            .COUNT_BITS (COUNT_BITS),
            .SW         (SW)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_pulse    (w_pulse[b]),
            .i_ctl      (w_ctl),
            .i_wr_addr  (w_wr_addr),
            .i_rd_addr  (w_rd_addr),
            .o_done_cnt (w_done_cnt[b]),
            .o_stored   (w_stored[b])
        );
    end

    // Merge lane results into the result fields
    assign o_done_count_a = w_done_cnt[0];
    assign o_stored_a     = w_stored[0];

    if (BANKS > 1) begin : g_out_b
        assign o_done_count_b = w_done_cnt[1];
        assign o_stored_b     = w_stored[1];
    end else begin : g_zero_b
        assign o_done_count_b = '0;
        assign o_stored_b     = '0;
    end

    if (BANKS > 2) begin : g_out_c
        assign o_done_count_c = w_done_cnt[2];
        assign o_stored_c     = w_stored[2];
    end else begin : g_zero_c
        assign o_done_count_c = '0;
        assign o_stored_c     = '0;
    end

    assign o_out_valid    = r_out_vld;
    assign o_power_on     = (o_phase != pcss_pkg::PHASE_IDLE);
    assign o_power_slot   = pcss_pkg::SLOT_FBITS'(w_ptr);
    assign o_reading_done = w_done;
    assign o_done_slot    = w_done ? pcss_pkg::SLOT_FBITS'(w_ptr) : '0;

    // Phase and count conditions watched by the checks below
    assign w_ph_idle   = (o_phase == pcss_pkg::PHASE_IDLE);
    assign w_ph_conv   = (o_phase == pcss_pkg::PHASE_CONV);
    assign w_ph_read   = (o_phase == pcss_pkg::PHASE_READ);
    assign w_idle_take = w_accept && w_ph_idle;
    assign w_cnt_zero  = (o_done_count_a == '0) && (o_done_count_b == '0) &&
                         (o_done_count_c == '0);

    // A finished readout always leaves the sequencer idle
    `PCSS_ASSERT_IMP(a_done_idle, r_out_vld && w_done, w_ph_idle, "readout ended outside idle")

    // An item taken in idle starts a conversion
    `PCSS_ASSERT_NXT(a_idle_conv, w_idle_take, w_ph_conv && r_out_vld, "idle item not converted")

    // Completed counts are zero unless a readout finished
    `PCSS_ASSERT_IMP(a_cnt_zero, r_out_vld && !w_done, w_cnt_zero, "done counts without readout")

    // Store writes happen only on a transfer
    `PCSS_ASSERT_IMP(a_wr_accept, w_ctl.wr_en, w_accept && w_ph_read, "stray store write")

endmodule

@@ rtl/core/pcss_ctrl.sv @@
// Phase sequencer: slot pointer, millisecond timer, config registers, store valid bits.
module pcss_ctrl #(
    parameter int SLOTS = pcss_pkg::SLOTS_DEF,
    parameter int SW    = $clog2(SLOTS)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  logic                                 i_ms_tick,
    input  logic [pcss_pkg::SLOT_FBITS-1:0]      i_read_slot,
    input  logic                                 i_cfg_we,
    input  logic [pcss_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [pcss_pkg::TIME_BITS-1:0]       i_cfg_data,
    output pcss_pkg::t_lane_ctl                  o_lane_ctl,
    output logic [SW-1:0]                        o_wr_addr,
    output logic [SW-1:0]                        o_rd_addr,
    output logic [pcss_pkg::PHASE_BITS-1:0]      o_phase,
    output logic [SW-1:0]                        o_ptr,
    output logic                                 o_done
);

    pcss_pkg::t_state                     r_state, n_state;
    logic [SW-1:0]                        r_ptr, n_ptr;
    logic [pcss_pkg::ELAPSED_BITS-1:0]    r_elapsed, n_elapsed;
    logic [pcss_pkg::ELAPSED_BITS-1:0]    w_el_inc;
    logic [pcss_pkg::TIME_BITS-1:0]       r_conv_time;
    logic [pcss_pkg::TIME_BITS-1:0]       r_readout_time;
    logic [SLOTS-1:0]                     r_vld;
    logic                                 r_done;
    logic                                 w_in_range;
    pcss_pkg::t_lane_ctl                  w_ctl;

    // Take configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conv_time    <= pcss_pkg::TIME_RESET;
            r_readout_time <= pcss_pkg::TIME_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == pcss_pkg::CFG_CONV_TIME) begin
                r_conv_time <= i_cfg_data;
            end
            if (i_cfg_index == pcss_pkg::CFG_READOUT_TIME) begin
                r_readout_time <= i_cfg_data;
            end
        end
    end

    // Saturating millisecond count including this item's tick
    assign w_el_inc = r_elapsed +
        pcss_pkg::ELAPSED_BITS'(i_ms_tick && (r_elapsed != pcss_pkg::ELAPSED_MAX));

    // Read address range check and store lookup controls
    assign w_in_range = (32'(i_read_slot) < SLOTS);
    assign o_rd_addr  = SW'(i_read_slot);
    assign o_wr_addr  = r_ptr;

    // Step the timer or the phase on every accepted item
    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_elapsed = r_elapsed;
        w_ctl     = '0;
        w_ctl.accept = i_accept;
        if (i_accept) begin
            unique case (r_state)
                pcss_pkg::ST_CONV: begin
                    if (w_el_inc >= r_conv_time) begin
                        w_ctl.count_clr = 1'b1;
                        n_state         = pcss_pkg::ST_READ;
                        n_elapsed       = '0;
                    end else begin
                        n_elapsed = w_el_inc;
                    end
                end
                pcss_pkg::ST_READ: begin
                    w_ctl.count_en = 1'b1;
                    if (w_el_inc >= r_readout_time) begin
                        w_ctl.wr_en = 1'b1;
                        n_state     = pcss_pkg::ST_IDLE;
                        n_elapsed   = '0;
                    end else begin
                        n_elapsed = w_el_inc;
                    end
                end
                default: begin
                    n_ptr     = (32'(r_ptr) == SLOTS - 1) ? '0 : r_ptr + SW'(1);
                    n_state   = pcss_pkg::ST_CONV;
                    n_elapsed = '0;
                end
            endcase
        end
        w_ctl.rd_ok  = w_in_range && r_vld[o_rd_addr];
        w_ctl.rd_byp = w_in_range && w_ctl.wr_en && (r_ptr == o_rd_addr);
    end

    // Advance sequencer state and mark written slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pcss_pkg::ST_IDLE;
            r_ptr     <= '0;
            r_elapsed <= '0;
            r_vld     <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_elapsed <= n_elapsed;
            if (w_ctl.wr_en) begin
                r_vld[r_ptr] <= 1'b1;
            end
            if (i_accept) begin
                r_done <= w_ctl.wr_en;
            end
        end
    end

    // Report the phase after the update
    always_comb begin
        unique case (r_state)
            pcss_pkg::ST_CONV: o_phase = pcss_pkg::PHASE_CONV;
            pcss_pkg::ST_READ: o_phase = pcss_pkg::PHASE_READ;
            default:           o_phase = pcss_pkg::PHASE_IDLE;
        endcase
    end

    assign o_lane_ctl = w_ctl;
    assign o_ptr      = r_ptr;
    assign o_done     = r_done;

endmodule

@@ rtl/core/pcss_lane.sv @@
// One bank lane: wrapping pulse counter and that bank's column of the reading store.
module pcss_lane #(
    parameter int SLOTS      = pcss_pkg::SLOTS_DEF,
    parameter int COUNT_BITS = pcss_pkg::COUNT_BITS_DEF,
    parameter int SW         = $clog2(SLOTS)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_pulse,
    input  pcss_pkg::t_lane_ctl               i_ctl,
    input  logic [SW-1:0]                     i_wr_addr,
    input  logic [SW-1:0]                     i_rd_addr,
    output logic [pcss_pkg::OUT_BITS-1:0]     o_done_cnt,
    output logic [pcss_pkg::OUT_BITS-1:0]     o_stored
);

    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [COUNT_BITS-1:0] r_done_cnt;
    logic [COUNT_BITS-1:0] r_mem_q;
    logic                  r_rd_ok;
    logic                  r_rd_byp;
    logic [COUNT_BITS-1:0] mem [SLOTS];

    // Count pulses in readout, clear when readout begins
    always_comb begin
        priority if (i_ctl.count_clr) begin
            n_count = '0;
        end else if (i_ctl.count_en) begin
            n_count = r_count + COUNT_BITS'(i_pulse);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Store column: write the finished count, register the read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= n_count;
        end
        if (i_ctl.accept) begin
            r_mem_q    <= mem[i_rd_addr];
            r_rd_ok    <= i_ctl.rd_ok;
            r_rd_byp   <= i_ctl.rd_byp;
            r_done_cnt <= i_ctl.wr_en ? n_count : '0;
        end
    end

    // Forward a same-item write, zero unwritten or out-of-range slots
    always_comb begin
        priority if (r_rd_byp) begin
            o_stored = pcss_pkg::OUT_BITS'(r_done_cnt);
        end else if (r_rd_ok) begin
            o_stored = pcss_pkg::OUT_BITS'(r_mem_q);
        end else begin
            o_stored = '0;
        end
    end

    assign o_done_cnt = pcss_pkg::OUT_BITS'(r_done_cnt);

endmodule
